### src/uxns_pkg.sv
// shared types, constants and classification tables for the xml name sanitizer
`default_nettype none
package uxns_pkg;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ANY   = 2'd1,
        CLS_LATER = 2'd2
    } cls_t;

    // one character as handed from the front to the back part
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;   // bytes to copy when passed, 1..3
        cls_t       cls;
        logic       eos;
    } char_t;

    localparam logic [7:0] UNDERSCORE = 8'h5f;

    function automatic logic in_rng(input logic [15:0] cp, input logic [15:0] lo,
                                    input logic [15:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    // letters: basechar, ideographic and underscore
    function automatic logic is_letter(input logic [15:0] c);
        logic r;
        r = (c == 16'h005f) ||
            in_rng(c,16'h0041,16'h005A) || in_rng(c,16'h0061,16'h007A) ||
            in_rng(c,16'h00C0,16'h00D6) || in_rng(c,16'h00D8,16'h00F6) ||
            in_rng(c,16'h00F8,16'h00FF) || in_rng(c,16'h0100,16'h0131) ||
            in_rng(c,16'h0134,16'h013E) || in_rng(c,16'h0141,16'h0148) ||
            in_rng(c,16'h014A,16'h017E) || in_rng(c,16'h0180,16'h01C3) ||
            in_rng(c,16'h01CD,16'h01F0) || in_rng(c,16'h01F4,16'h01F5) ||
            in_rng(c,16'h01FA,16'h0217) || in_rng(c,16'h0250,16'h02A8) ||
            in_rng(c,16'h02BB,16'h02C1) || in_rng(c,16'h0386,16'h0386) ||
            in_rng(c,16'h0388,16'h038A) || in_rng(c,16'h038C,16'h038C) ||
            in_rng(c,16'h038E,16'h03A1) || in_rng(c,16'h03A3,16'h03CE) ||
            in_rng(c,16'h03D0,16'h03D6) || in_rng(c,16'h03DA,16'h03DA) ||
            in_rng(c,16'h03DC,16'h03DC) || in_rng(c,16'h03DE,16'h03DE) ||
            in_rng(c,16'h03E0,16'h03E0) || in_rng(c,16'h03E2,16'h03F3) ||
            in_rng(c,16'h0401,16'h040C) || in_rng(c,16'h040E,16'h044F) ||
            in_rng(c,16'h0451,16'h045C) || in_rng(c,16'h045E,16'h0481) ||
            in_rng(c,16'h0490,16'h04C4) || in_rng(c,16'h04C7,16'h04C8) ||
            in_rng(c,16'h04CB,16'h04CC) || in_rng(c,16'h04D0,16'h04EB) ||
            in_rng(c,16'h04EE,16'h04F5) || in_rng(c,16'h04F8,16'h04F9) ||
            in_rng(c,16'h0531,16'h0556) || in_rng(c,16'h0559,16'h0559) ||
            in_rng(c,16'h0561,16'h0586) || in_rng(c,16'h05D0,16'h05EA) ||
            in_rng(c,16'h05F0,16'h05F2) || in_rng(c,16'h0621,16'h063A) ||
            in_rng(c,16'h0641,16'h064A) || in_rng(c,16'h0671,16'h06B7) ||
            in_rng(c,16'h06BA,16'h06BE) || in_rng(c,16'h06C0,16'h06CE) ||
            in_rng(c,16'h06D0,16'h06D3) || in_rng(c,16'h06D5,16'h06D5) ||
            in_rng(c,16'h06E5,16'h06E6) || in_rng(c,16'h0905,16'h0939) ||
            in_rng(c,16'h093D,16'h093D) || in_rng(c,16'h0958,16'h0961) ||
            in_rng(c,16'h0985,16'h098C) || in_rng(c,16'h098F,16'h0990) ||
            in_rng(c,16'h0993,16'h09A8) || in_rng(c,16'h09AA,16'h09B0) ||
            in_rng(c,16'h09B2,16'h09B2) || in_rng(c,16'h09B6,16'h09B9) ||
            in_rng(c,16'h09DC,16'h09DD) || in_rng(c,16'h09DF,16'h09E1) ||
            in_rng(c,16'h09F0,16'h09F1) || in_rng(c,16'h0A05,16'h0A0A) ||
            in_rng(c,16'h0A0F,16'h0A10) || in_rng(c,16'h0A13,16'h0A28) ||
            in_rng(c,16'h0A2A,16'h0A30) || in_rng(c,16'h0A32,16'h0A33) ||
            in_rng(c,16'h0A35,16'h0A36) || in_rng(c,16'h0A38,16'h0A39) ||
            in_rng(c,16'h0A59,16'h0A5C) || in_rng(c,16'h0A5E,16'h0A5E) ||
            in_rng(c,16'h0A72,16'h0A74) || in_rng(c,16'h0A85,16'h0A8B) ||
            in_rng(c,16'h0A8D,16'h0A8D) || in_rng(c,16'h0A8F,16'h0A91) ||
            in_rng(c,16'h0A93,16'h0AA8) || in_rng(c,16'h0AAA,16'h0AB0) ||
            in_rng(c,16'h0AB2,16'h0AB3) || in_rng(c,16'h0AB5,16'h0AB9) ||
            in_rng(c,16'h0ABD,16'h0ABD) || in_rng(c,16'h0AE0,16'h0AE0) ||
            in_rng(c,16'h0B05,16'h0B0C) || in_rng(c,16'h0B0F,16'h0B10) ||
            in_rng(c,16'h0B13,16'h0B28) || in_rng(c,16'h0B2A,16'h0B30) ||
            in_rng(c,16'h0B32,16'h0B33) || in_rng(c,16'h0B36,16'h0B39) ||
            in_rng(c,16'h0B3D,16'h0B3D) || in_rng(c,16'h0B5C,16'h0B5D) ||
            in_rng(c,16'h0B5F,16'h0B61) || in_rng(c,16'h0B85,16'h0B8A) ||
            in_rng(c,16'h0B8E,16'h0B90) || in_rng(c,16'h0B92,16'h0B95) ||
            in_rng(c,16'h0B99,16'h0B9A) || in_rng(c,16'h0B9C,16'h0B9C) ||
            in_rng(c,16'h0B9E,16'h0B9F) || in_rng(c,16'h0BA3,16'h0BA4) ||
            in_rng(c,16'h0BA8,16'h0BAA) || in_rng(c,16'h0BAE,16'h0BB5) ||
            in_rng(c,16'h0BB7,16'h0BB9) || in_rng(c,16'h0C05,16'h0C0C) ||
            in_rng(c,16'h0C0E,16'h0C10) || in_rng(c,16'h0C12,16'h0C28) ||
            in_rng(c,16'h0C2A,16'h0C33) || in_rng(c,16'h0C35,16'h0C39) ||
            in_rng(c,16'h0C60,16'h0C61) || in_rng(c,16'h0C85,16'h0C8C) ||
            in_rng(c,16'h0C8E,16'h0C90) || in_rng(c,16'h0C92,16'h0CA8) ||
            in_rng(c,16'h0CAA,16'h0CB3) || in_rng(c,16'h0CB5,16'h0CB9) ||
            in_rng(c,16'h0CDE,16'h0CDE) || in_rng(c,16'h0CE0,16'h0CE1) ||
            in_rng(c,16'h0D05,16'h0D0C) || in_rng(c,16'h0D0E,16'h0D10) ||
            in_rng(c,16'h0D12,16'h0D28) || in_rng(c,16'h0D2A,16'h0D39) ||
            in_rng(c,16'h0D60,16'h0D61) || in_rng(c,16'h0E01,16'h0E2E) ||
            in_rng(c,16'h0E30,16'h0E30) || in_rng(c,16'h0E32,16'h0E33) ||
            in_rng(c,16'h0E40,16'h0E45) || in_rng(c,16'h0E81,16'h0E82) ||
            in_rng(c,16'h0E84,16'h0E84) || in_rng(c,16'h0E87,16'h0E88) ||
            in_rng(c,16'h0E8A,16'h0E8A) || in_rng(c,16'h0E8D,16'h0E8D) ||
            in_rng(c,16'h0E94,16'h0E97) || in_rng(c,16'h0E99,16'h0E9F) ||
            in_rng(c,16'h0EA1,16'h0EA3) || in_rng(c,16'h0EA5,16'h0EA5) ||
            in_rng(c,16'h0EA7,16'h0EA7) || in_rng(c,16'h0EAA,16'h0EAB) ||
            in_rng(c,16'h0EAD,16'h0EAE) || in_rng(c,16'h0EB0,16'h0EB0) ||
            in_rng(c,16'h0EB2,16'h0EB3) || in_rng(c,16'h0EBD,16'h0EBD) ||
            in_rng(c,16'h0EC0,16'h0EC4) || in_rng(c,16'h0F40,16'h0F47) ||
            in_rng(c,16'h0F49,16'h0F69) || in_rng(c,16'h10A0,16'h10C5) ||
            in_rng(c,16'h10D0,16'h10F6) || in_rng(c,16'h1100,16'h1100) ||
            in_rng(c,16'h1102,16'h1103) || in_rng(c,16'h1105,16'h1107) ||
            in_rng(c,16'h1109,16'h1109) || in_rng(c,16'h110B,16'h110C) ||
            in_rng(c,16'h110E,16'h1112) || in_rng(c,16'h113C,16'h113C) ||
            in_rng(c,16'h113E,16'h113E) || in_rng(c,16'h1140,16'h1140) ||
            in_rng(c,16'h114C,16'h114C) || in_rng(c,16'h114E,16'h114E) ||
            in_rng(c,16'h1150,16'h1150) || in_rng(c,16'h1154,16'h1155) ||
            in_rng(c,16'h1159,16'h1159) || in_rng(c,16'h115F,16'h1161) ||
            in_rng(c,16'h1163,16'h1163) || in_rng(c,16'h1165,16'h1165) ||
            in_rng(c,16'h1167,16'h1167) || in_rng(c,16'h1169,16'h1169) ||
            in_rng(c,16'h116D,16'h116E) || in_rng(c,16'h1172,16'h1173) ||
            in_rng(c,16'h1175,16'h1175) || in_rng(c,16'h119E,16'h119E) ||
            in_rng(c,16'h11A8,16'h11A8) || in_rng(c,16'h11AB,16'h11AB) ||
            in_rng(c,16'h11AE,16'h11AF) || in_rng(c,16'h11B7,16'h11B8) ||
            in_rng(c,16'h11BA,16'h11BA) || in_rng(c,16'h11BC,16'h11C2) ||
            in_rng(c,16'h11EB,16'h11EB) || in_rng(c,16'h11F0,16'h11F0) ||
            in_rng(c,16'h11F9,16'h11F9) || in_rng(c,16'h1E00,16'h1E9B) ||
            in_rng(c,16'h1EA0,16'h1EF9) || in_rng(c,16'h1F00,16'h1F15) ||
            in_rng(c,16'h1F18,16'h1F1D) || in_rng(c,16'h1F20,16'h1F45) ||
            in_rng(c,16'h1F48,16'h1F4D) || in_rng(c,16'h1F50,16'h1F57) ||
            in_rng(c,16'h1F59,16'h1F59) || in_rng(c,16'h1F5B,16'h1F5B) ||
            in_rng(c,16'h1F5D,16'h1F5D) || in_rng(c,16'h1F5F,16'h1F7D) ||
            in_rng(c,16'h1F80,16'h1FB4) || in_rng(c,16'h1FB6,16'h1FBC) ||
            in_rng(c,16'h1FBE,16'h1FBE) || in_rng(c,16'h1FC2,16'h1FC4) ||
            in_rng(c,16'h1FC6,16'h1FCC) || in_rng(c,16'h1FD0,16'h1FD3) ||
            in_rng(c,16'h1FD6,16'h1FDB) || in_rng(c,16'h1FE0,16'h1FEC) ||
            in_rng(c,16'h1FF2,16'h1FF4) || in_rng(c,16'h1FF6,16'h1FFC) ||
            in_rng(c,16'h2126,16'h2126) || in_rng(c,16'h212A,16'h212B) ||
            in_rng(c,16'h212E,16'h212E) || in_rng(c,16'h2180,16'h2182) ||
            in_rng(c,16'h3041,16'h3094) || in_rng(c,16'h30A1,16'h30FA) ||
            in_rng(c,16'h3105,16'h312C) || in_rng(c,16'hAC00,16'hD7A3) ||
            in_rng(c,16'h3007,16'h3007) || in_rng(c,16'h3021,16'h3029) ||
            in_rng(c,16'h4E00,16'h9FA5);
        return r;
    endfunction

    // digits, extenders, combining marks, '.' and '-'
    function automatic logic is_later(input logic [15:0] c);
        logic r;
        r = (c == 16'h002e) || (c == 16'h002d) ||
            in_rng(c,16'h0030,16'h0039) || in_rng(c,16'h0660,16'h0669) ||
            in_rng(c,16'h06F0,16'h06F9) || in_rng(c,16'h0966,16'h096F) ||
            in_rng(c,16'h09E6,16'h09EF) || in_rng(c,16'h0A66,16'h0A6F) ||
            in_rng(c,16'h0AE6,16'h0AEF) || in_rng(c,16'h0B66,16'h0B6F) ||
            in_rng(c,16'h0BE7,16'h0BEF) || in_rng(c,16'h0C66,16'h0C6F) ||
            in_rng(c,16'h0CE6,16'h0CEF) || in_rng(c,16'h0D66,16'h0D6F) ||
            in_rng(c,16'h0E50,16'h0E59) || in_rng(c,16'h0ED0,16'h0ED9) ||
            in_rng(c,16'h0F20,16'h0F29) ||
            (c == 16'h00B7) || (c == 16'h02D0) || (c == 16'h02D1) ||
            (c == 16'h0387) || (c == 16'h0640) || (c == 16'h0E46) ||
            (c == 16'h0EC6) || (c == 16'h3005) || in_rng(c,16'h3031,16'h3035) ||
            in_rng(c,16'h309D,16'h309E) || in_rng(c,16'h30FC,16'h30FE) ||
            in_rng(c,16'h0300,16'h0345) || in_rng(c,16'h0360,16'h0361) ||
            in_rng(c,16'h0483,16'h0486) || in_rng(c,16'h0591,16'h05A1) ||
            in_rng(c,16'h05A3,16'h05B9) || in_rng(c,16'h05BB,16'h05BD) ||
            in_rng(c,16'h05BF,16'h05BF) || in_rng(c,16'h05C1,16'h05C2) ||
            in_rng(c,16'h05C4,16'h05C4) || in_rng(c,16'h064B,16'h0652) ||
            in_rng(c,16'h0670,16'h0670) || in_rng(c,16'h06D6,16'h06E4) ||
            in_rng(c,16'h06E7,16'h06E8) || in_rng(c,16'h06EA,16'h06ED) ||
            in_rng(c,16'h0901,16'h0903) || in_rng(c,16'h093C,16'h093C) ||
            in_rng(c,16'h093E,16'h094D) || in_rng(c,16'h0951,16'h0954) ||
            in_rng(c,16'h0962,16'h0963) || in_rng(c,16'h0981,16'h0983) ||
            in_rng(c,16'h09BC,16'h09BC) || in_rng(c,16'h09BE,16'h09C4) ||
            in_rng(c,16'h09C7,16'h09C8) || in_rng(c,16'h09CB,16'h09CD) ||
            in_rng(c,16'h09D7,16'h09D7) || in_rng(c,16'h09E2,16'h09E3) ||
            in_rng(c,16'h0A02,16'h0A02) || in_rng(c,16'h0A3C,16'h0A3C) ||
            in_rng(c,16'h0A3E,16'h0A42) || in_rng(c,16'h0A47,16'h0A48) ||
            in_rng(c,16'h0A4B,16'h0A4D) || in_rng(c,16'h0A70,16'h0A71) ||
            in_rng(c,16'h0A81,16'h0A83) || in_rng(c,16'h0ABC,16'h0ABC) ||
            in_rng(c,16'h0ABE,16'h0AC5) || in_rng(c,16'h0AC7,16'h0AC9) ||
            in_rng(c,16'h0ACB,16'h0ACD) || in_rng(c,16'h0B01,16'h0B03) ||
            in_rng(c,16'h0B3C,16'h0B3C) || in_rng(c,16'h0B3E,16'h0B43) ||
            in_rng(c,16'h0B47,16'h0B48) || in_rng(c,16'h0B4B,16'h0B4D) ||
            in_rng(c,16'h0B56,16'h0B57) || in_rng(c,16'h0B82,16'h0B83) ||
            in_rng(c,16'h0BBE,16'h0BC2) || in_rng(c,16'h0BC6,16'h0BC8) ||
            in_rng(c,16'h0BCA,16'h0BCD) || in_rng(c,16'h0BD7,16'h0BD7) ||
            in_rng(c,16'h0C01,16'h0C03) || in_rng(c,16'h0C3E,16'h0C44) ||
            in_rng(c,16'h0C46,16'h0C48) || in_rng(c,16'h0C4A,16'h0C4D) ||
            in_rng(c,16'h0C55,16'h0C56) || in_rng(c,16'h0C82,16'h0C83) ||
            in_rng(c,16'h0CBE,16'h0CC4) || in_rng(c,16'h0CC6,16'h0CC8) ||
            in_rng(c,16'h0CCA,16'h0CCD) || in_rng(c,16'h0CD5,16'h0CD6) ||
            in_rng(c,16'h0D02,16'h0D03) || in_rng(c,16'h0D3E,16'h0D43) ||
            in_rng(c,16'h0D46,16'h0D48) || in_rng(c,16'h0D4A,16'h0D4D) ||
            in_rng(c,16'h0D57,16'h0D57) || in_rng(c,16'h0E31,16'h0E31) ||
            in_rng(c,16'h0E34,16'h0E3A) || in_rng(c,16'h0E47,16'h0E4E) ||
            in_rng(c,16'h0EB1,16'h0EB1) || in_rng(c,16'h0EB4,16'h0EB9) ||
            in_rng(c,16'h0EBB,16'h0EBC) || in_rng(c,16'h0EC8,16'h0ECD) ||
            in_rng(c,16'h0F18,16'h0F19) || in_rng(c,16'h0F35,16'h0F35) ||
            in_rng(c,16'h0F37,16'h0F37) || in_rng(c,16'h0F39,16'h0F39) ||
            in_rng(c,16'h0F3E,16'h0F3F) || in_rng(c,16'h0F71,16'h0F84) ||
            in_rng(c,16'h0F86,16'h0F8B) || in_rng(c,16'h0F90,16'h0F95) ||
            in_rng(c,16'h0F97,16'h0F97) || in_rng(c,16'h0F99,16'h0FAD) ||
            in_rng(c,16'h0FB1,16'h0FB7) || in_rng(c,16'h0FB9,16'h0FB9) ||
            in_rng(c,16'h20D0,16'h20DC) || in_rng(c,16'h20E1,16'h20E1) ||
            in_rng(c,16'h302A,16'h302F) || in_rng(c,16'h3099,16'h309A);
        return r;
    endfunction

endpackage
`default_nettype wire

### src/uxns_front.sv
// front part: gathers utf-8 sequences, decodes and classifies each character
`default_nettype none
module uxns_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_eos,
    output logic               ch_valid,
    input  wire logic          ch_ready,
    output uxns_pkg::char_t    ch_data
);
    import uxns_pkg::*;

    logic [2:0]  exp_reg, exp_next;
    logic [2:0]  held_reg, held_next;
    logic [15:0] cp_reg, cp_next;
    logic [7:0]  b0_reg, b1_reg;
    logic [2:0]  len;
    logic        take, done, busy;
    logic [2:0]  exp_eff, held_eff;
    logic [15:0] cp_eff;
    logic [7:0]  b0_eff, b1_eff, b2_eff;
    logic [1:0]  rem;
    char_t       ch_reg, ch_c;
    logic        chv_reg;

    assign in_ready = !chv_reg || ch_ready;
    assign take     = in_valid && in_ready;
    assign busy     = (exp_reg != 3'd0);
    assign ch_valid = chv_reg;
    assign ch_data  = ch_reg;

    // sequence length from the lead byte
    always_comb begin
        if (!in_byte[7])                 len = 3'd1;
        else if (in_byte[7:5] == 3'b110) len = 3'd2;
        else if (in_byte[7:4] == 4'he)   len = 3'd3;
        else if (in_byte[7:3] == 5'h1e)  len = 3'd4;
        else if (in_byte[7:2] == 6'h3e)  len = 3'd5;
        else if (in_byte[7:1] == 7'h7e)  len = 3'd6;
        else                             len = 3'd1;
    end

    // decode step for this byte
    always_comb begin
        b0_eff = b0_reg;
        b1_eff = b1_reg;
        b2_eff = in_byte;
        rem    = 2'd0;
        if (!busy) begin
            exp_eff  = len;
            held_eff = 3'd1;
            b0_eff   = in_byte;
            unique case (len)
                3'd1:    cp_eff = in_byte[7] ? 16'd0 : {8'd0, in_byte};
                3'd2:    cp_eff = {5'd0, in_byte[4:0], 6'd0};
                3'd3:    cp_eff = {in_byte[3:0], 12'd0};
                default: cp_eff = 16'd0;
            endcase
        end else begin
            exp_eff  = exp_reg;
            held_eff = held_reg + 3'd1;
            if (held_reg == 3'd1) b1_eff = in_byte;
            cp_eff = cp_reg;
            if (exp_reg <= 3'd3) begin
                rem    = {1'b0, 1'(exp_reg - held_reg - 3'd1)};
                cp_eff = cp_reg | (rem[0] ? {4'd0, in_byte[5:0], 6'd0}
                                          : {10'd0, in_byte[5:0]});
            end
        end
        done = (held_eff >= exp_eff);
    end

    // character record for the queue
    always_comb begin
        ch_c.b0     = b0_eff;
        ch_c.b1     = b1_eff;
        ch_c.b2     = b2_eff;
        ch_c.nbytes = (exp_eff >= 3'd3) ? 2'd3 : exp_eff[1:0];
        ch_c.eos    = in_eos;
        if (!done || exp_eff > 3'd3)  ch_c.cls = CLS_NONE;
        else if (is_letter(cp_eff))   ch_c.cls = CLS_ANY;
        else if (is_later(cp_eff))    ch_c.cls = CLS_LATER;
        else                          ch_c.cls = CLS_NONE;
        exp_next  = exp_reg;
        held_next = held_reg;
        cp_next   = cp_reg;
        if (take) begin
            if (done || in_eos) begin
                exp_next  = 3'd0;
                held_next = 3'd0;
                cp_next   = 16'd0;
            end else begin
                exp_next  = exp_eff;
                held_next = held_eff;
                cp_next   = cp_eff;
            end
        end
    end

    // gatherer state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg  <= 3'd0;
            held_reg <= 3'd0;
            cp_reg   <= 16'd0;
            chv_reg  <= 1'b0;
        end else begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            cp_reg   <= cp_next;
            if (take) chv_reg <= done || in_eos;
            else if (ch_ready) chv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            b0_reg <= b0_eff;
            b1_reg <= b1_eff;
            ch_reg <= ch_c;
        end
    end
endmodule
`default_nettype wire

### src/uxns_queue.sv
// short fifo of classified characters between front and back
`default_nettype none
module uxns_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire uxns_pkg::char_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output uxns_pkg::char_t    rd_data
);
    import uxns_pkg::*;

    char_t      mem [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

### src/uxns_back.sv
// back part: expands each classified character into output bytes
`default_nettype none
module uxns_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          ch_valid,
    output logic               ch_ready,
    input  wire uxns_pkg::char_t ch_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_run_last,
    output logic               out_string_last
);
    import uxns_pkg::*;

    logic       first_reg;
    logic [1:0] idx_reg;
    logic [2:0] n;
    logic [7:0] bytes [4];
    logic [7:0] sel;
    logic       last, adv;
    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       orl_reg, osl_reg;
    logic       can_load;

    // list of output bytes for the head character
    always_comb begin
        bytes[0] = UNDERSCORE;
        bytes[1] = UNDERSCORE;
        bytes[2] = UNDERSCORE;
        bytes[3] = UNDERSCORE;
        case (ch_data.cls)
            CLS_NONE: n = 3'd1;
            CLS_LATER: begin
                if (first_reg) begin
                    bytes[1] = ch_data.b0;
                    bytes[2] = ch_data.b1;
                    bytes[3] = ch_data.b2;
                    n = {1'b0, ch_data.nbytes} + 3'd1;
                end else begin
                    bytes[0] = ch_data.b0;
                    bytes[1] = ch_data.b1;
                    bytes[2] = ch_data.b2;
                    n = {1'b0, ch_data.nbytes};
                end
            end
            default: begin
                bytes[0] = ch_data.b0;
                bytes[1] = ch_data.b1;
                bytes[2] = ch_data.b2;
                n = {1'b0, ch_data.nbytes};
            end
        endcase
        sel  = bytes[idx_reg];
        last = ({1'b0, idx_reg} == n - 3'd1);
    end

    assign can_load = !ov_reg || out_ready;
    assign adv      = ch_valid && can_load;
    assign ch_ready = adv && last;
    assign out_valid       = ov_reg;
    assign out_byte        = ob_reg;
    assign out_run_last    = orl_reg;
    assign out_string_last = osl_reg;

    // byte index, first-char flag and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            idx_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end else begin
            if (adv) begin
                ov_reg <= 1'b1;
                if (last) begin
                    idx_reg   <= 2'd0;
                    first_reg <= ch_data.eos;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ob_reg  <= sel;
            orl_reg <= last;
            osl_reg <= last && ch_data.eos;
        end
    end
endmodule
`default_nettype wire

### src/utf8_xml_name_sanitizer_top.sv
// top level of the utf-8 to xml name sanitizer
// Rewrites each UTF-8 string into a valid XML 1.0 name. The front decodes and
// classifies a byte in the cycle it is accepted; a two-entry queue decouples
// it from the back, which sends one output byte per cycle when not stalled. A
// valid character of k bytes gives k output bytes (k+1 with a '_' prefix), any
// other one a single '_'. Unless stalled, the input takes one byte per cycle
// except when a prefix is added; the back's single output port sets that limit.
`default_nettype none
module utf8_xml_name_sanitizer_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // in_byte
    input  wire logic       s_tlast,    // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // out_byte
    output logic            m_tuser,    // run_last
    output logic            m_tlast     // string_last
);
    import uxns_pkg::*;

    logic  f_valid, f_ready, q_valid, q_ready;
    char_t f_data, q_data;

    uxns_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_eos(s_tlast),
        .ch_valid(f_valid), .ch_ready(f_ready), .ch_data(f_data)
    );

    uxns_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    uxns_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .ch_valid(q_valid), .ch_ready(q_ready), .ch_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_byte(m_tdata), .out_run_last(m_tuser), .out_string_last(m_tlast)
    );
endmodule
`default_nettype wire
